// ----- rtl/core/tgt_pkg.sv -----
package tgt_pkg;

    localparam int NUM_GAINS = 3;
    localparam int OUT_GAINS = 3;
    localparam int GAIN_W    = 32;
    localparam int STEP_W    = 32;
    localparam int SPEED_W   = 16;
    localparam int ERR_W     = 16;
    localparam int ISTEP_W   = 16;
    localparam int TOL_W     = 20;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;
    localparam int IDX_W     = (NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 1;
    localparam int SUM_W     = STEP_W + $clog2(NUM_GAINS + 1);
    localparam int OUT_DW    = OUT_GAINS * GAIN_W + ERR_W;

    localparam logic [ISTEP_W-1:0] INIT_STEP_RST = ISTEP_W'(655);
    localparam logic [TOL_W-1:0]   STOP_TOL_RST  = TOL_W'(328);

    // floor(y / 5) = (y * RECIP5) >> 34 for any 32-bit y
    localparam logic [31:0] RECIP5       = 32'hCCCC_CCCD;
    localparam int          RECIP5_SHIFT = 34;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PLUS,
        PH_MINUS,
        PH_DONE
    } t_phase;

    typedef enum logic [CFG_AW-1:0] {
        CFG_TARGET_SPEED,
        CFG_INITIAL_KP,
        CFG_INITIAL_KD,
        CFG_INITIAL_KI,
        CFG_INITIAL_STEP,
        CFG_STOP_TOLERANCE
    } t_cfg_idx;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TRIAL = 1'b1;

    // gain +/- step, saturated to the signed 32-bit range
    function automatic logic [GAIN_W-1:0] probe_gain(
        input logic [GAIN_W-1:0] g,
        input logic [STEP_W-1:0] s,
        input logic              minus
    );
        logic [GAIN_W+1:0] sum;
        sum = minus ? ({{2{g[GAIN_W-1]}}, g} - {2'b00, s})
                    : ({{2{g[GAIN_W-1]}}, g} + {2'b00, s});
        if (sum[GAIN_W+1:GAIN_W-1] == 3'b000 || sum[GAIN_W+1:GAIN_W-1] == 3'b111) begin
            probe_gain = sum[GAIN_W-1:0];
        end else if (sum[GAIN_W+1]) begin
            probe_gain = {1'b1, {(GAIN_W-1){1'b0}}};
        end else begin
            probe_gain = {1'b0, {(GAIN_W-1){1'b1}}};
        end
    endfunction

endpackage

// ----- rtl/core/twiddle_gain_tuner_top.sv -----
// Twiddle (coordinate descent) search over three PID gains. A beat with
// tuser 0 starts a search from the configuration registers and takes its
// tdata speed as the baseline; a beat with tuser 1 reports the speed reached
// with the gains of the previous result. Every input beat gives exactly one
// result beat carrying the gains to apply next, the best error so far and a
// done flag in tuser. One beat is taken per clock unless the output stalls;
// each result passes the input register, then the result register, and
// the clock rate is set by the step grow/shrink path, a constant reciprocal
// multiply followed by the step-sum compare and the saturating probe add.
// The user must write configuration only while no beat is in flight (unenforced).
module twiddle_gain_tuner_top
    import tgt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [SPEED_W-1:0] s_axis_tdata,  // measured_speed
    input  logic              s_axis_tuser,   // command
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // trial_kp, trial_kd, trial_ki, best_error
    output logic              m_axis_tuser    // done_res
);

    logic signed [SPEED_W-1:0] r_target;
    logic [GAIN_W-1:0]         r_init_gain [OUT_GAINS];
    logic [ISTEP_W-1:0]        r_init_step;
    logic [TOL_W-1:0]          r_stop_tol;

    logic                      r_in_valid;
    logic                      r_cmd;
    logic signed [SPEED_W-1:0] r_speed;

    logic [GAIN_W-1:0] r_gain  [NUM_GAINS];
    logic [STEP_W-1:0] r_step  [NUM_GAINS];
    logic [GAIN_W-1:0] r_trial [NUM_GAINS];
    logic [ERR_W-1:0]  r_lowest;
    logic [IDX_W-1:0]  r_idx;
    t_phase            r_phase;

    logic [GAIN_W-1:0] n_gain  [NUM_GAINS];
    logic [STEP_W-1:0] n_step  [NUM_GAINS];
    logic [GAIN_W-1:0] n_trial [NUM_GAINS];
    logic [ERR_W-1:0]  n_lowest;
    logic [IDX_W-1:0]  n_idx;
    t_phase            n_phase;

    logic              r_out_valid;
    logic [OUT_DW-1:0] r_out_data;
    logic              r_out_done;
    logic [OUT_DW-1:0] n_out_data;

    logic w_fire;
    logic w_probe;
    logic w_minus;

    // error
    logic signed [SPEED_W:0] w_diff;
    logic [ERR_W-1:0]        w_err;

    // step grow / shrink of the current gain
    logic [STEP_W-1:0] w_cur_step;
    logic [STEP_W:0]   w_x;
    logic [63:0]       w_prod;
    logic [STEP_W-1:0] w_q;
    logic [3:0]        w_q10;
    logic [3:0]        w_rem;
    logic [STEP_W:0]   w_grow_sum;
    logic [STEP_W-1:0] w_grow;
    logic [STEP_W-1:0] w_shrink;

    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_done;

    assign w_diff = {r_target[SPEED_W-1], r_target} - {r_speed[SPEED_W-1], r_speed};
    assign w_err  = w_diff[SPEED_W] ? ERR_W'(-w_diff) : ERR_W'(w_diff);

    // floor((s + 4) / 10) via halving and a reciprocal of 5
    assign w_cur_step = r_step[r_idx];
    assign w_x        = {1'b0, w_cur_step} + (STEP_W+1)'(4);
    assign w_prod     = {32'b0, w_x[STEP_W:1]} * {32'b0, RECIP5};
    assign w_q        = STEP_W'(w_prod[63:RECIP5_SHIFT]);
    assign w_q10      = {w_q[0], 3'b000} + {w_q[2:0], 1'b0};
    assign w_rem      = w_x[3:0] - w_q10;
    assign w_grow_sum = {1'b0, w_cur_step} + {1'b0, w_q} + (STEP_W+1)'(w_rem == 4'd9);
    assign w_grow     = w_grow_sum[STEP_W] ? {STEP_W{1'b1}} : w_grow_sum[STEP_W-1:0];
    assign w_shrink   = w_cur_step - w_q;

    // next search state
    always_comb begin
        logic             adv;
        logic             check;
        logic [IDX_W:0]   idx_inc;
        logic [SUM_W-1:0] sum;
        adv      = 1'b0;
        check    = 1'b0;
        sum      = '0;
        idx_inc  = {1'b0, r_idx} + (IDX_W+1)'(1);
        w_probe  = 1'b0;
        w_minus  = 1'b0;
        n_gain   = r_gain;
        n_step   = r_step;
        n_lowest = r_lowest;
        n_idx    = r_idx;
        n_phase  = r_phase;
        if (r_cmd == CMD_START) begin
            for (int i = 0; i < NUM_GAINS; i++) begin
                n_gain[i] = (i < OUT_GAINS) ? r_init_gain[i] : '0;
                n_step[i] = STEP_W'(r_init_step);
            end
            n_lowest = w_err;
            n_idx    = '0;
            check    = 1'b1;
        end else if (r_phase == PH_PLUS || r_phase == PH_MINUS) begin
            if (w_err < r_lowest) begin
                n_lowest       = w_err;
                n_gain[r_idx]  = r_trial[r_idx];
                n_step[r_idx]  = w_grow;
                adv            = 1'b1;
            end else if (r_phase == PH_PLUS) begin
                n_phase = PH_MINUS;
                w_probe = 1'b1;
                w_minus = 1'b1;
            end else begin
                n_step[r_idx] = w_shrink;
                adv           = 1'b1;
            end
        end
        if (adv) begin
            if (idx_inc == (IDX_W+1)'(NUM_GAINS)) begin
                n_idx = '0;
                check = 1'b1;
            end else begin
                n_idx   = idx_inc[IDX_W-1:0];
                n_phase = PH_PLUS;
                w_probe = 1'b1;
            end
        end
        for (int i = 0; i < NUM_GAINS; i++) begin
            sum = sum + SUM_W'(n_step[i]);
        end
        if (check) begin
            if (sum <= SUM_W'(r_stop_tol)) begin
                n_phase = PH_DONE;
            end else begin
                n_phase = PH_PLUS;
                w_probe = 1'b1;
            end
        end
    end

    // trial gains and result beat
    always_comb begin
        n_trial = n_gain;
        if (w_probe) begin
            n_trial[n_idx] = probe_gain(n_gain[n_idx], n_step[n_idx], w_minus);
        end
        n_out_data = '0;
        for (int i = 0; i < OUT_GAINS; i++) begin
            if (i < NUM_GAINS) begin
                n_out_data[i*GAIN_W +: GAIN_W] = n_trial[i];
            end
        end
        n_out_data[OUT_GAINS*GAIN_W +: ERR_W] = n_lowest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_init_step <= INIT_STEP_RST;
            r_stop_tol  <= STOP_TOL_RST;
            for (int i = 0; i < OUT_GAINS; i++) begin
                r_init_gain[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TARGET_SPEED:   r_target       <= i_cfg_wdata[SPEED_W-1:0];
                CFG_INITIAL_KP:     r_init_gain[0] <= i_cfg_wdata[GAIN_W-1:0];
                CFG_INITIAL_KD:     r_init_gain[1] <= i_cfg_wdata[GAIN_W-1:0];
                CFG_INITIAL_KI:     r_init_gain[2] <= i_cfg_wdata[GAIN_W-1:0];
                CFG_INITIAL_STEP:   r_init_step    <= i_cfg_wdata[ISTEP_W-1:0];
                CFG_STOP_TOLERANCE: r_stop_tol     <= i_cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd   <= s_axis_tuser;
            r_speed <= s_axis_tdata;
        end
    end

    // search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest <= '0;
            r_idx    <= '0;
            r_phase  <= PH_IDLE;
            for (int i = 0; i < NUM_GAINS; i++) begin
                r_gain[i]  <= '0;
                r_step[i]  <= '0;
                r_trial[i] <= '0;
            end
        end else if (w_fire) begin
            r_lowest <= n_lowest;
            r_idx    <= n_idx;
            r_phase  <= n_phase;
            r_gain   <= n_gain;
            r_step   <= n_step;
            r_trial  <= n_trial;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= n_out_data;
            r_out_done <= (n_phase == PH_DONE);
        end
    end

    a_done_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (m_axis_tuser == (r_phase == PH_DONE)))
        else $error("done flag disagrees with search phase");

    a_idx_zero_when_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE || r_phase == PH_DONE) |-> (r_idx == '0))
        else $error("gain index not zero outside a sweep");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_idx} < (IDX_W+1)'(NUM_GAINS)))
        else $error("gain index out of range");

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_cmd == CMD_START) |=> (r_idx == '0 && r_phase != PH_IDLE))
        else $error("start beat did not restart the search");

    a_lowest_never_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_cmd == CMD_TRIAL) |=> (r_lowest <= $past(r_lowest)))
        else $error("best error rose on a trial beat");

endmodule
